// ===== rtl/core/pnc_pkg.sv =====
// ============================================================================
// pnc_pkg: shared types and constants for the polygon near-plane clip block
// Holds the screen geometry, the fixed-point widths, the sequencer states,
// the configuration register indexes and the divider request/response types.
// ============================================================================
`default_nettype none

package pnc_pkg;

    // Screen geometry in pixels.
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    // Screen center in Q12.4, given as a 62-bit signed value for the final sums.
    localparam logic signed [61:0] CENTER_X = 62'(SCREEN_WIDTH * 8);
    localparam logic signed [61:0] CENTER_Y = 62'(SCREEN_HEIGHT * 8);

    // Fixed-point widths.
    localparam int DEP_W  = 28;  // depth and lateral, Q.8
    localparam int PLAT_W = 29;  // clamped lateral of a projected point
    localparam int MUL_W  = 30;  // shared multiplier operand width
    localparam int PRD_W  = 60;  // shared multiplier product width
    localparam int DEN_W  = 33;  // signed divisor width
    localparam int QUO_W  = 61;  // signed quotient width

    // Rounding offset for the Q1.14 direction products.
    localparam logic signed [PRD_W-1:0] ROUND14 = 60'sd8192;

    // Lateral clamp for intersection points.
    localparam logic signed [61:0] LAT_MAX = 62'sd134217728;
    localparam logic signed [61:0] LAT_MIN = -62'sd134217728;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_CAMERA_X      = 3'd0,
        CFG_CAMERA_Y      = 3'd1,
        CFG_VIEW_COS      = 3'd2,
        CFG_VIEW_SIN      = 3'd3,
        CFG_EYE_HEIGHT    = 3'd4,
        CFG_NEAR_DISTANCE = 3'd5,
        CFG_FOCAL_LENGTH  = 3'd6
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D0, ST_D1, ST_D2,
        ST_L0, ST_L1, ST_L2,
        ST_PLAN, ST_NEXT,
        ST_C0, ST_C1, ST_C2,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
        ST_OUT, ST_END
    } t_state;

    // Divider request and response.
    typedef struct packed {
        logic                    start;
        logic signed [PRD_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quot;
    } t_div_rsp;

    // Saturate a wide signed sum to 16 bits signed.
    function automatic logic signed [15:0] sat16(input logic signed [61:0] v);
        logic signed [15:0] r;
        if (v > 62'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -62'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pnc_div.sv =====
// ============================================================================
// pnc_div: shared rounding divider
// Signed division rounded half away from zero, one quotient bit per cycle
// with a restoring remainder. Done is a registered pulse after the last bit.
// ============================================================================
`default_nettype none

module pnc_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire pnc_pkg::t_div_req i_req,
    output pnc_pkg::t_div_rsp o_rsp
);

    localparam int NW = pnc_pkg::PRD_W;
    localparam int DW = pnc_pkg::DEN_W;

    logic [NW-1:0] r_dvd;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_neg;
    logic          r_done;

    logic [NW-1:0] un;
    logic [DW-1:0] ud;
    logic [DW:0]   rem_sh;
    logic          bit_q;
    logic [DW:0]   rem_sub;

    // Magnitudes of the request; half the divisor is added for rounding.
    always_comb begin
        un      = i_req.num[NW-1] ? NW'(-i_req.num) : NW'(i_req.num);
        ud      = i_req.den[DW-1] ? DW'(-i_req.den) : DW'(i_req.den);
        rem_sh  = {r_rem, r_dvd[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        bit_q   = (rem_sh >= {1'b0, r_den});
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one dividend bit and subtract when it fits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= un + NW'(ud >> 1);
            r_den <= ud;
            r_rem <= '0;
            r_neg <= i_req.num[NW-1] ^ i_req.den[DW-1];
        end else if (r_busy) begin
            r_rem <= bit_q ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_dvd <= {r_dvd[NW-2:0], bit_q};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

endmodule

`default_nettype wire

// ===== rtl/core/polygon_near_clip_project.sv =====
// ============================================================================
// polygon_near_clip_project: near-plane polygon clip and perspective project
// Clips each polygon edge against the near plane and projects kept vertices
// and intersection points to screen coordinates with a shared multiplier
// and a shared divider under a small sequencer.
// ============================================================================
//
//  channel   signals                                       direction
//  -------   -------------------------------------------   ---------
//  vertex    i_valid/o_ready, i_vertex_x/y, i_surface_   in
//            height, i_last_vertex
//  result    o_valid/i_ready, o_screen_x/y, o_vertex_    out
//            valid, o_end_of_polygon
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata             in
//
//  Each vertex first forms its depth and lateral products; each projected point
//  then takes two divides and each intersection one more, all on the shared
//  60-step divider.
//  Up to three results per vertex; each waits in the output register until
//  taken, and the sequencer holds meanwhile. o_ready is high only when idle.
//  Reset is synchronous and active low; it loads the register defaults.
// ============================================================================
`default_nettype none

module polygon_near_clip_project (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire         [2:0] i_cfg_idx,
    input  wire        [23:0] i_cfg_wdata,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire signed [23:0] i_vertex_x,
    input  wire signed [23:0] i_vertex_y,
    input  wire signed [23:0] i_surface_height,
    input  wire               i_last_vertex,
    output logic              o_valid,
    input  wire               i_ready,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic              o_vertex_valid,
    output logic              o_end_of_polygon
);

    localparam int DW = pnc_pkg::DEP_W;
    localparam int PW = pnc_pkg::PLAT_W;
    localparam int MW = pnc_pkg::MUL_W;
    localparam int RW = pnc_pkg::PRD_W;

    pnc_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic signed [23:0] r_cam_x, r_cam_y, r_eye;
    logic signed [15:0] r_cos, r_sin;
    logic        [22:0] r_near;
    logic        [19:0] r_focal;

    // Current request.
    logic signed [23:0] r_vx, r_vy, r_h;
    logic               r_last;

    // Polygon state.
    logic signed [23:0]   r_first_vx, r_first_vy, r_prev_vx, r_prev_vy;
    logic signed [DW-1:0] r_first_depth, r_prev_depth;
    logic                 r_prev_front, r_inside;

    // Working registers.
    logic signed [DW-1:0] r_d, r_lat_cur, r_lat_prev, r_lat_first;
    logic                 r_front;
    logic [1:0]           r_pt;
    logic [2:0]           r_todo;
    logic                 r_any;
    logic                 r_edge;
    logic signed [PW-1:0] r_plat;
    logic signed [DW-1:0] r_pdep;
    logic signed [RW-1:0] r_prod, r_acc;
    logic signed [15:0]   r_sx;

    // Output register.
    logic               r_out_valid;
    logic signed [15:0] r_out_sx, r_out_sy;
    logic               r_out_vv, r_out_eop;

    pnc_pkg::t_div_req div_req;
    pnc_pkg::t_div_rsp div_rsp;

    logic        [22:0]   nr_eff;
    logic signed [DW-1:0] nr_s;
    logic signed [23:0]   px, py;
    logic signed [24:0]   dx, dy;
    logic signed [MW-1:0] m_a, m_b;
    logic signed [RW-1:0] sum_d, sum_l, rnd_d, rnd_l;
    logic signed [DW-1:0] d_val, l_val;
    logic signed [DW-1:0] la, lb, da, db;
    logic signed [PW-1:0] near_m_da, lb_m_la;
    logic signed [61:0]   lx_sum, s_sum;
    logic signed [24:0]   eye_m_h;

    // Effective near distance and the point whose offsets feed the multiplier.
    always_comb begin
        nr_eff = (r_near == 23'd0) ? 23'd1 : r_near;
        nr_s   = $signed({5'b0, nr_eff});
        case (r_pt)
            2'd1: begin
                px = r_prev_vx;
                py = r_prev_vy;
            end
            2'd2: begin
                px = r_first_vx;
                py = r_first_vy;
            end
            default: begin
                px = r_vx;
                py = r_vy;
            end
        endcase
        dx = {px[23], px} - {r_cam_x[23], r_cam_x};
        dy = {py[23], py} - {r_cam_y[23], r_cam_y};
    end

    // Edge endpoints: incoming edge runs prev to current, closing edge current to first.
    always_comb begin
        if (r_edge) begin
            la = r_lat_cur;
            da = r_d;
            lb = r_lat_first;
            db = r_first_depth;
        end else begin
            la = r_lat_prev;
            da = r_prev_depth;
            lb = r_lat_cur;
            db = r_d;
        end
        near_m_da = {1'b0, nr_s} - {da[DW-1], da};
        lb_m_la   = {lb[DW-1], lb} - {la[DW-1], la};
        eye_m_h   = {r_eye[23], r_eye} - {r_h[23], r_h};
    end

    // Depth and lateral rounding of the Q1.14 products.
    always_comb begin
        sum_d = r_acc + r_prod;
        sum_l = r_acc - r_prod;
        rnd_d = (sum_d + pnc_pkg::ROUND14) >>> 14;
        rnd_l = (sum_l + pnc_pkg::ROUND14) >>> 14;
        d_val = rnd_d[DW-1:0];
        l_val = rnd_l[DW-1:0];
        lx_sum = {{(62-DW){la[DW-1]}}, la} + {div_rsp.quot[pnc_pkg::QUO_W-1], div_rsp.quot};
        s_sum  = ((r_state == pnc_pkg::ST_P2) ? pnc_pkg::CENTER_X : pnc_pkg::CENTER_Y)
                 + {div_rsp.quot[pnc_pkg::QUO_W-1], div_rsp.quot};
    end

    // Shared multiplier operand selection.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            pnc_pkg::ST_D0: begin
                m_a = MW'(dx);
                m_b = MW'(r_cos);
            end
            pnc_pkg::ST_D1: begin
                m_a = MW'(dy);
                m_b = MW'(r_sin);
            end
            pnc_pkg::ST_L0: begin
                m_a = MW'(dy);
                m_b = MW'(r_cos);
            end
            pnc_pkg::ST_L1: begin
                m_a = MW'(dx);
                m_b = MW'(r_sin);
            end
            pnc_pkg::ST_C0: begin
                m_a = MW'(near_m_da);
                m_b = MW'(lb_m_la);
            end
            pnc_pkg::ST_P0: begin
                m_a = $signed({10'b0, r_focal});
                m_b = MW'(r_plat);
            end
            pnc_pkg::ST_P3: begin
                m_a = $signed({10'b0, r_focal});
                m_b = MW'(eye_m_h);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Divider requests.
    always_comb begin
        div_req.start = (r_state == pnc_pkg::ST_C1) || (r_state == pnc_pkg::ST_P1) ||
                        (r_state == pnc_pkg::ST_P4);
        div_req.num   = r_prod;
        if (r_state == pnc_pkg::ST_C1) begin
            div_req.den = pnc_pkg::DEN_W'($signed({db[DW-1], db} - {da[DW-1], da}));
        end else begin
            div_req.den = $signed({r_pdep[DW-1], r_pdep, 4'b0});
        end
    end

    pnc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pnc_pkg::ST_IDLE: if (i_valid) n_state = pnc_pkg::ST_D0;
            pnc_pkg::ST_D0:   n_state = pnc_pkg::ST_D1;
            pnc_pkg::ST_D1:   n_state = pnc_pkg::ST_D2;
            pnc_pkg::ST_D2:   n_state = pnc_pkg::ST_L0;
            pnc_pkg::ST_L0:   n_state = pnc_pkg::ST_L1;
            pnc_pkg::ST_L1:   n_state = pnc_pkg::ST_L2;
            pnc_pkg::ST_L2:   n_state = (r_pt == 2'd2) ? pnc_pkg::ST_PLAN : pnc_pkg::ST_L0;
            pnc_pkg::ST_PLAN: n_state = pnc_pkg::ST_NEXT;
            pnc_pkg::ST_NEXT: begin
                if (r_todo[0] || (!r_todo[1] && r_todo[2])) begin
                    n_state = pnc_pkg::ST_C0;
                end else if (r_todo[1]) begin
                    n_state = pnc_pkg::ST_P0;
                end else if (r_last && !r_any) begin
                    n_state = pnc_pkg::ST_OUT;
                end else begin
                    n_state = pnc_pkg::ST_END;
                end
            end
            pnc_pkg::ST_C0:   n_state = (db == da) ? pnc_pkg::ST_P0 : pnc_pkg::ST_C1;
            pnc_pkg::ST_C1:   n_state = pnc_pkg::ST_C2;
            pnc_pkg::ST_C2:   if (div_rsp.done) n_state = pnc_pkg::ST_P0;
            pnc_pkg::ST_P0:   n_state = pnc_pkg::ST_P1;
            pnc_pkg::ST_P1:   n_state = pnc_pkg::ST_P2;
            pnc_pkg::ST_P2:   if (div_rsp.done) n_state = pnc_pkg::ST_P3;
            pnc_pkg::ST_P3:   n_state = pnc_pkg::ST_P4;
            pnc_pkg::ST_P4:   n_state = pnc_pkg::ST_P5;
            pnc_pkg::ST_P5:   if (div_rsp.done) n_state = pnc_pkg::ST_OUT;
            pnc_pkg::ST_OUT:  if (i_ready) n_state = pnc_pkg::ST_NEXT;
            pnc_pkg::ST_END:  n_state = pnc_pkg::ST_IDLE;
            default:          n_state = pnc_pkg::ST_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cos   <= 16'sd16384;
            r_sin   <= '0;
            r_eye   <= '0;
            r_near  <= 23'd256;
            r_focal <= 20'd81920;
        end else if (i_cfg_we) begin
            case (pnc_pkg::t_cfg_idx'(i_cfg_idx))
                pnc_pkg::CFG_CAMERA_X:      r_cam_x <= i_cfg_wdata;
                pnc_pkg::CFG_CAMERA_Y:      r_cam_y <= i_cfg_wdata;
                pnc_pkg::CFG_VIEW_COS:      r_cos   <= i_cfg_wdata[15:0];
                pnc_pkg::CFG_VIEW_SIN:      r_sin   <= i_cfg_wdata[15:0];
                pnc_pkg::CFG_EYE_HEIGHT:    r_eye   <= i_cfg_wdata;
                pnc_pkg::CFG_NEAR_DISTANCE: r_near  <= i_cfg_wdata[22:0];
                pnc_pkg::CFG_FOCAL_LENGTH:  r_focal <= i_cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    // Polygon state and output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_vx    <= '0;
            r_first_vy    <= '0;
            r_first_depth <= '0;
            r_prev_vx     <= '0;
            r_prev_vy     <= '0;
            r_prev_depth  <= '0;
            r_prev_front  <= 1'b0;
            r_inside      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            case (r_state)
                pnc_pkg::ST_D2: begin
                    if (!r_inside) begin
                        r_first_vx    <= r_vx;
                        r_first_vy    <= r_vy;
                        r_first_depth <= d_val;
                    end
                end
                pnc_pkg::ST_NEXT: begin
                    if (r_todo == 3'b000 && r_last && !r_any) begin
                        r_out_valid <= 1'b1;
                    end
                end
                pnc_pkg::ST_P5: begin
                    if (div_rsp.done) r_out_valid <= 1'b1;
                end
                pnc_pkg::ST_OUT: begin
                    if (i_ready) r_out_valid <= 1'b0;
                end
                pnc_pkg::ST_END: begin
                    r_prev_vx    <= r_vx;
                    r_prev_vy    <= r_vy;
                    r_prev_depth <= r_d;
                    r_prev_front <= r_front;
                    r_inside     <= !r_last;
                end
                default: ;
            endcase
        end
    end

    // Working datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= RW'(m_a * m_b);
        case (r_state)
            pnc_pkg::ST_IDLE: begin
                r_vx   <= i_vertex_x;
                r_vy   <= i_vertex_y;
                r_h    <= i_surface_height;
                r_last <= i_last_vertex;
                r_pt   <= 2'd0;
                r_any  <= 1'b0;
            end
            pnc_pkg::ST_D1: r_acc <= r_prod;
            pnc_pkg::ST_D2: begin
                r_d     <= d_val;
                r_front <= (d_val > nr_s);
            end
            pnc_pkg::ST_L1: r_acc <= r_prod;
            pnc_pkg::ST_L2: begin
                case (r_pt)
                    2'd1:    r_lat_prev  <= l_val;
                    2'd2:    r_lat_first <= l_val;
                    default: r_lat_cur   <= l_val;
                endcase
                r_pt <= r_pt + 2'd1;
            end
            pnc_pkg::ST_PLAN: begin
                r_todo[0] <= r_inside && (r_prev_front != r_front);
                r_todo[1] <= r_front;
                r_todo[2] <= r_last && (r_front != (r_first_depth > nr_s));
            end
            pnc_pkg::ST_NEXT: begin
                if (r_todo[0]) begin
                    r_edge    <= 1'b0;
                    r_todo[0] <= 1'b0;
                end else if (r_todo[1]) begin
                    r_plat    <= PW'(r_lat_cur);
                    r_pdep    <= r_d;
                    r_todo[1] <= 1'b0;
                end else if (r_todo[2]) begin
                    r_edge    <= 1'b1;
                    r_todo[2] <= 1'b0;
                end else if (r_last && !r_any) begin
                    // Empty end marker when the last vertex yields no screen point.
                    r_out_sx  <= '0;
                    r_out_sy  <= '0;
                    r_out_vv  <= 1'b0;
                    r_out_eop <= 1'b1;
                    r_any     <= 1'b1;
                end
            end
            pnc_pkg::ST_C0: begin
                r_plat <= PW'(la);
                r_pdep <= nr_s;
            end
            pnc_pkg::ST_C2: begin
                if (lx_sum > pnc_pkg::LAT_MAX) begin
                    r_plat <= PW'(pnc_pkg::LAT_MAX);
                end else if (lx_sum < pnc_pkg::LAT_MIN) begin
                    r_plat <= PW'(pnc_pkg::LAT_MIN);
                end else begin
                    r_plat <= lx_sum[PW-1:0];
                end
            end
            pnc_pkg::ST_P2: begin
                if (div_rsp.done) r_sx <= pnc_pkg::sat16(s_sum);
            end
            pnc_pkg::ST_P5: begin
                if (div_rsp.done) begin
                    r_out_sx  <= r_sx;
                    r_out_sy  <= pnc_pkg::sat16(s_sum);
                    r_out_vv  <= 1'b1;
                    r_out_eop <= r_last && (r_todo == 3'b000);
                    r_any     <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_ready          = (r_state == pnc_pkg::ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_screen_x       = r_out_sx;
    assign o_screen_y       = r_out_sy;
    assign o_vertex_valid   = r_out_vv;
    assign o_end_of_polygon = r_out_eop;

endmodule

`default_nettype wire

// ===== test/polygon_near_clip_project_tb.sv =====
// ============================================================================
// polygon_near_clip_project_tb: self-checking bench for the near-plane clipper
// Feeds polygons through the vertex channel and checks every screen point
// against a table value or a cycle-free predictor of the clip and
// projection arithmetic. A short directed table comes first, then
// near-distance cases, then random polygons under several camera settings.
// ============================================================================
`timescale 1ns / 100ps

module polygon_near_clip_project_tb;

    localparam int  CLK_PERIOD  = 10;
    localparam int  DRAIN_WAIT  = 700;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  RANDOM_ITEMS = 330;
    localparam int  CALM_ITEMS  = 60;

    // One screen point as the block reports it.
    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               vv;
        logic               eop;
    } t_screen_pt;

    // One row of the directed table.
    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] h;
        logic               last;
        bit                 typed;
        t_screen_pt         pt;
    } t_vertex_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic         [2:0] i_cfg_idx;
    logic        [23:0] i_cfg_wdata;
    logic               i_valid;
    logic               o_ready;
    logic signed [23:0] i_vertex_x;
    logic signed [23:0] i_vertex_y;
    logic signed [23:0] i_surface_height;
    logic               i_last_vertex;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_screen_x;
    logic signed [15:0] o_screen_y;
    logic               o_vertex_valid;
    logic               o_end_of_polygon;

    polygon_near_clip_project uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_vertex_x      (i_vertex_x),
        .i_vertex_y      (i_vertex_y),
        .i_surface_height(i_surface_height),
        .i_last_vertex   (i_last_vertex),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_vertex_valid  (o_vertex_valid),
        .o_end_of_polygon(o_end_of_polygon)
    );

    // Camera registers as the block should hold them.
    longint cam_x, cam_y, dir_cos, dir_sin, eye_h, near_d, focal;

    // Polygon walk state of the predictor.
    longint fst_x, fst_y, prv_x, prv_y;
    int     fst_dep, prv_dep;
    bit     prv_front, in_poly;

    t_screen_pt step_pts[$];
    t_screen_pt pending_pts[$];

    int  mismatches;
    int  cycles;
    bit  calm;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Arithmetic of the clip and projection.
    function automatic longint round_q14(longint p);
        longint v;
        v = p + 8192;
        if (v >= 0) return v >>> 14;
        return -((-v + 16383) >>> 14);
    endfunction

    function automatic longint div_round(longint num, longint den);
        longint un, ud, q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint near_eff();
        return (near_d < 1) ? 1 : near_d;
    endfunction

    function automatic longint depth_at(longint x, longint y);
        return round_q14((x - cam_x) * dir_cos + (y - cam_y) * dir_sin);
    endfunction

    function automatic longint lateral_at(longint x, longint y);
        return round_q14((y - cam_y) * dir_cos - (x - cam_x) * dir_sin);
    endfunction

    function automatic void push_point(longint lat, longint dep, longint h);
        t_screen_pt p;
        p.sx  = clamp16(5120 + div_round(focal * lat, dep * 16));
        p.sy  = clamp16(3840 + div_round(focal * (eye_h - h), dep * 16));
        p.vv  = 1'b1;
        p.eop = 1'b0;
        step_pts.insert(step_pts.size(), p);
    endfunction

    // Point where the edge a->b meets the near plane.
    function automatic void push_cross(longint ax, longint ay, longint da,
                                       longint bx, longint by, longint db,
                                       longint h);
        longint nr, la, lb, lx;
        nr = near_eff();
        la = lateral_at(ax, ay);
        lb = lateral_at(bx, by);
        lx = la;
        if (db != da) lx = la + div_round((nr - da) * (lb - la), db - da);
        if (lx > 134217728) lx = 134217728;
        if (lx < -134217728) lx = -134217728;
        push_point(lx, nr, h);
    endfunction

    // Screen points caused by one vertex request, left in step_pts.
    function automatic void predict_vertex(longint vx, longint vy, longint h,
                                           bit last);
        longint nr, d;
        bit front;
        t_screen_pt blank;
        step_pts.delete();
        nr = near_eff();
        d = depth_at(vx, vy);
        front = d > nr;
        if (!in_poly) begin
            fst_x = vx;
            fst_y = vy;
            fst_dep = int'(d);
        end else if (prv_front != front) begin
            push_cross(prv_x, prv_y, prv_dep, vx, vy, d, h);
        end
        if (front) push_point(lateral_at(vx, vy), d, h);
        prv_x = vx;
        prv_y = vy;
        prv_dep = int'(d);
        prv_front = front;
        if (last) begin
            if (front != (longint'(fst_dep) > nr))
                push_cross(vx, vy, d, fst_x, fst_y, fst_dep, h);
            if (step_pts.size() == 0) begin
                blank = '{16'sd0, 16'sd0, 1'b0, 1'b0};
                step_pts.insert(0, blank);
            end
            step_pts[step_pts.size() - 1].eop = 1'b1;
            in_poly = 1'b0;
        end else begin
            in_poly = 1'b1;
        end
    endfunction

    // Present one vertex request and hold it until accepted.
    task automatic send_vertex(logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] h, logic last,
                               bit typed, t_screen_pt pt);
        i_valid          <= 1'b1;
        i_vertex_x       <= x;
        i_vertex_y       <= y;
        i_surface_height <= h;
        i_last_vertex    <= last;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        predict_vertex(x, y, h, last);
        if (typed) begin
            pending_pts.insert(pending_pts.size(), pt);
        end else begin
            foreach (step_pts[k]) pending_pts.insert(pending_pts.size(), step_pts[k]);
        end
    endtask

    // Random gap between requests; none during the calm tail.
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Let the block drain before a register write.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // One register write; the write enable stays up for back-to-back writes.
    task automatic cfg_write(pnc_pkg::t_cfg_idx idx, logic [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            pnc_pkg::CFG_CAMERA_X:      cam_x   = longint'($signed(data));
            pnc_pkg::CFG_CAMERA_Y:      cam_y   = longint'($signed(data));
            pnc_pkg::CFG_VIEW_COS:      dir_cos = longint'($signed(data[15:0]));
            pnc_pkg::CFG_VIEW_SIN:      dir_sin = longint'($signed(data[15:0]));
            pnc_pkg::CFG_EYE_HEIGHT:    eye_h   = longint'($signed(data));
            pnc_pkg::CFG_NEAR_DISTANCE: near_d  = longint'(data[22:0]);
            pnc_pkg::CFG_FOCAL_LENGTH:  focal   = longint'(data[19:0]);
            default: ;
        endcase
    endtask

    // Close a run of register writes.
    task automatic cfg_stop();
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(logic [23:0] cx, logic [23:0] cy, logic [15:0] c,
                           logic [15:0] s, logic [23:0] eh, logic [22:0] nd,
                           logic [19:0] fl);
        cfg_write(pnc_pkg::CFG_CAMERA_X, cx);
        cfg_write(pnc_pkg::CFG_CAMERA_Y, cy);
        cfg_write(pnc_pkg::CFG_VIEW_COS, {8'h00, c});
        cfg_write(pnc_pkg::CFG_VIEW_SIN, {8'h00, s});
        cfg_write(pnc_pkg::CFG_EYE_HEIGHT, eh);
        cfg_write(pnc_pkg::CFG_NEAR_DISTANCE, {1'b0, nd});
        cfg_write(pnc_pkg::CFG_FOCAL_LENGTH, {4'h0, fl});
        cfg_stop();
    endtask

    function automatic t_screen_pt mk_pt(int sx, int sy, bit vv, bit eop);
        t_screen_pt p;
        p.sx = sx[15:0];
        p.sy = sy[15:0];
        p.vv = vv;
        p.eop = eop;
        return p;
    endfunction

    function automatic t_vertex_row mk_row(int x, int y, int h, bit last);
        t_vertex_row r;
        r.x = x[23:0];
        r.y = y[23:0];
        r.h = h[23:0];
        r.last = last;
        r.typed = 1'b0;
        r.pt = mk_pt(0, 0, 0, 0);
        return r;
    endfunction

    function automatic t_vertex_row mk_typed(int x, int y, int h, t_screen_pt p);
        t_vertex_row r;
        r = mk_row(x, y, h, 1'b1);
        r.typed = 1'b1;
        r.pt = p;
        return r;
    endfunction

    // Random coordinate near the camera, or anywhere in range.
    function automatic logic signed [23:0] pick_coord(longint center, int span);
        longint v;
        if ($urandom_range(0, 9) == 0) return 24'($urandom());
        v = center + $signed($urandom_range(0, 2 * span)) - span;
        return v[23:0];
    endfunction

    // Stimulus.
    initial begin
        t_vertex_row rows[$];
        t_screen_pt  none;
        int          items, n_vtx, span, phase;
        logic signed [23:0] h;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = pnc_pkg::CFG_CAMERA_X;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_vertex_x = '0;
        i_vertex_y = '0;
        i_surface_height = '0;
        i_last_vertex = 1'b0;
        cycles = 0;
        mismatches = 0;
        calm = 1'b0;
        cam_x = 0; cam_y = 0; dir_cos = 16384; dir_sin = 0;
        eye_h = 0; near_d = 256; focal = 81920;
        fst_x = 0; fst_y = 0; prv_x = 0; prv_y = 0;
        fst_dep = 0; prv_dep = 0; prv_front = 0; in_poly = 0;
        none = mk_pt(0, 0, 0, 0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset settings.
        rows.insert(rows.size(), mk_typed(0, 0, 0, mk_pt(0, 0, 0, 1)));
        rows.insert(rows.size(), mk_typed(512, 0, 0, mk_pt(5120, 3840, 1, 1)));
        rows.insert(rows.size(), mk_typed(8388607, 0, 0, mk_pt(5120, 3840, 1, 1)));
        rows.insert(rows.size(), mk_typed(8388607, 8388607, -8388608,
                                          mk_pt(10240, 8960, 1, 1)));
        rows.insert(rows.size(), mk_typed(-8388608, -8388608, 8388607,
                                          mk_pt(0, 0, 0, 1)));
        rows.insert(rows.size(), mk_typed(512, -8388608, 0, mk_pt(-32768, 3840, 1, 1)));
        rows.insert(rows.size(), mk_typed(512, 8388607, 0, mk_pt(32767, 3840, 1, 1)));
        rows.insert(rows.size(), mk_typed(512, 0, -8388608, mk_pt(5120, 32767, 1, 1)));
        rows.insert(rows.size(), mk_typed(512, 0, 8388607, mk_pt(5120, -32768, 1, 1)));
        rows.insert(rows.size(), mk_row(-1024, 0, 256, 0));
        rows.insert(rows.size(), mk_row(1024, 512, 256, 0));
        rows.insert(rows.size(), mk_row(1024, -512, -256, 0));
        rows.insert(rows.size(), mk_row(2048, 0, 0, 1));
        rows.insert(rows.size(), mk_row(1024, 0, 100, 0));
        rows.insert(rows.size(), mk_row(-512, 700, 100, 0));
        rows.insert(rows.size(), mk_row(0, 1024, 100, 1));
        rows.insert(rows.size(), mk_row(-300, 40, 0, 0));
        rows.insert(rows.size(), mk_row(-200, -40, 0, 1));
        foreach (rows[k]) begin
            send_vertex(rows[k].x, rows[k].y, rows[k].h, rows[k].last,
                        rows[k].typed, rows[k].pt);
            maybe_pause();
        end

        // Near distance raised inside a polygon: crossing edge of equal depths.
        send_vertex(24'sd1024, 24'sd0, 24'sd0, 1'b0, 1'b0, none);
        wait_quiet();
        cfg_write(pnc_pkg::CFG_NEAR_DISTANCE, 24'd2048);
        cfg_stop();
        send_vertex(24'sd1024, 24'sd512, 24'sd0, 1'b1, 1'b0, none);
        wait_quiet();

        // Near distance of zero acts as one.
        cfg_write(pnc_pkg::CFG_NEAR_DISTANCE, 24'd0);
        cfg_stop();
        send_vertex(24'sd1, 24'sd0, 24'sd0, 1'b1, 1'b0, none);
        send_vertex(24'sd2, 24'sd0, 24'sd0, 1'b1, 1'b0, none);

        // Random polygons across several camera settings.
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS) begin
            wait_quiet();
            case (phase)
                0: cfg_all(24'h7FFFFF, 24'h800000, 16'hC000, 16'h4000,
                           24'h7FFFFF, 23'd1, 20'd1);
                1: cfg_all(24'h800000, 24'h7FFFFF, 16'h0000, 16'hC000,
                           24'h800000, 23'h7FFFFF, 20'hFFFFF);
                2: cfg_all(24'd0, 24'd0, 16'd16384, 16'd0, 24'd512, 23'd256,
                           20'd81920);
                default: cfg_all(24'($urandom()), 24'($urandom()),
                                 16'($signed($urandom_range(0, 32768)) - 16384),
                                 16'($signed($urandom_range(0, 32768)) - 16384),
                                 24'($urandom()), 23'($urandom_range(1, 4096)),
                                 20'($urandom_range(1, 1048575)));
            endcase
            phase++;
            repeat (8) begin
                n_vtx = $urandom_range(1, 6);
                case ($urandom_range(0, 2))
                    0: span = 512;
                    1: span = 8192;
                    default: span = 262144;
                endcase
                h = ($urandom_range(0, 4) == 0) ? 24'($urandom())
                                                : 24'($urandom_range(0, 8192));
                for (int v = 0; v < n_vtx; v++) begin
                    if ($urandom_range(0, 5) == 0)
                        h = 24'($urandom_range(0, 8192));
                    calm = (items >= RANDOM_ITEMS - CALM_ITEMS);
                    send_vertex(pick_coord(cam_x, span), pick_coord(cam_y, span),
                                h, v == n_vtx - 1, 1'b0, none);
                    items++;
                    maybe_pause();
                end
            end
        end

        // Drain and report.
        i_valid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: random stalls and the check against the oldest expectation.
    initial begin
        int         stall;
        t_screen_pt want;
        i_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready && i_rst_n) begin
                if (pending_pts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point: x=%0d y=%0d v=%b e=%b",
                                 o_screen_x, o_screen_y, o_vertex_valid,
                                 o_end_of_polygon);
                end else begin
                    want = pending_pts.pop_front();
                    if (o_screen_x !== want.sx || o_screen_y !== want.sy ||
                        o_vertex_valid !== want.vv ||
                        o_end_of_polygon !== want.eop) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"point mismatch: expected x=%0d y=%0d v=%b e=%b,",
                                      " got x=%0d y=%0d v=%b e=%b"},
                                     want.sx, want.sy, want.vv, want.eop,
                                     o_screen_x, o_screen_y, o_vertex_valid,
                                     o_end_of_polygon);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 17);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

endmodule
